// File: hw/rtl/afus_pkg.sv
// shared types and codes for the audio fec unit sequencer
// depends on nothing; used by the controller, datapath, top level and checker
package afus_pkg;

    localparam int HDR_W  = 88;  // packed input header bits
    localparam int ODAT_W = 40;  // packed result data bits
    localparam int OUSR_W = 4;   // status plus fec flag

    localparam logic [7:0]  CODEC_OK   = 8'd5;
    localparam logic [15:0] HALF_RANGE = 16'd32768;

    typedef enum logic [2:0] {
        STAT_DELIVERED = 3'd0,
        STAT_STALE     = 3'd1,
        STAT_SKIP      = 3'd2,
        STAT_BAD_CODEC = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_COUNT     = 3'd5,
        STAT_SIZE      = 3'd6,
        STAT_TOO_MANY  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_UNITS
    } state_t;

    typedef struct packed {
        logic load_hdr;   // capture accepted header
        logic start;      // header passed, set up unit walk
        logic emit_err;   // load the single error result
        logic emit_unit;  // load the result for the current unit
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_err;    // header failed a check
        logic unit_last;  // current unit is the final one
    } dp_status_t;

endpackage

// File: hw/rtl/afus_ctrl.sv
// controller state machine of the audio fec unit sequencer
// depends on afus_pkg; drives the datapath through ctrl_cmd_t
module afus_ctrl import afus_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!dp_stat.has_err) state_next = S_UNITS;
                else if (out_free) state_next = S_IDLE;
            end
            S_UNITS: begin
                if (out_free && dp_stat.unit_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_hdr = s_tvalid;
            end
            S_CHECK: begin
                cmd.start    = !dp_stat.has_err;
                cmd.emit_err = dp_stat.has_err && out_free;
            end
            S_UNITS: begin
                cmd.emit_unit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // output slot fills on a load, drains when the receiver takes it
    always_comb begin
        if (cmd.emit_err || cmd.emit_unit) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

endmodule

// File: hw/rtl/afus_datapath.sv
// datapath of the audio fec unit sequencer: header checks, unit walk, frame state
// depends on afus_pkg; commanded by afus_ctrl
module afus_datapath import afus_pkg::*; #(
    parameter int MAX_UNITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [HDR_W-1:0]  s_tdata,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        dp_stat,
    output logic [ODAT_W-1:0] m_tdata,
    output logic [OUSR_W-1:0] m_tuser,
    output logic              m_tlast
);

    localparam int UW = $clog2(MAX_UNITS + 1);

    logic [7:0]  codec_reg, src_reg, fec_reg, usize_reg;
    logic [15:0] fi_reg, total_reg;
    logic [23:0] bytes_reg;

    logic [UW-1:0] idx_reg;
    logic [13:0]   offset_reg;
    logic [15:0]   last_frame_reg;
    logic          startup_reg;

    status_t     o_status_reg;
    logic [15:0] o_frame_reg;
    logic [13:0] o_offset_reg;
    logic [7:0]  o_len_reg;
    logic        o_fec_reg, o_last_reg;

    status_t     err_code;
    logic [23:0] size_prod;
    logic [8:0]  n_units, idx_ext;
    logic        is_src, skip, newer, unit_last;
    logic [7:0]  k;
    logic [15:0] frame, diff;

    // header checks, first failure wins
    assign size_prod = 24'(usize_reg) * 24'(total_reg);
    always_comb begin
        err_code = STAT_DELIVERED;
        if (codec_reg != CODEC_OK) err_code = STAT_BAD_CODEC;
        else if (bytes_reg == 24'd0) err_code = STAT_EMPTY;
        else if (16'({1'b0, src_reg} + {1'b0, fec_reg}) != total_reg) err_code = STAT_COUNT;
        else if (bytes_reg != size_prod) err_code = STAT_SIZE;
        else if (total_reg > 16'(MAX_UNITS)) err_code = STAT_TOO_MANY;
    end

    // current unit
    assign n_units   = {1'b0, src_reg} + {1'b0, fec_reg};
    assign idx_ext   = 9'(idx_reg);
    assign is_src    = idx_ext < {1'b0, src_reg};
    assign k         = 8'(idx_ext - {1'b0, src_reg});
    assign frame     = is_src ? fi_reg + 16'(idx_reg)
                              : fi_reg - 16'(fec_reg) + 16'(k);
    assign skip      = !is_src && startup_reg &&
                       ({1'b0, fi_reg} + 17'(k) < 17'(fec_reg) + 17'd1);
    // serial order: newer when the wrapped difference is nonzero and below half range
    assign diff      = frame - last_frame_reg;
    assign newer     = (diff != 16'd0) && (diff < HALF_RANGE);
    assign unit_last = (idx_ext + 9'd1) == n_units;

    assign dp_stat.has_err   = err_code != STAT_DELIVERED;
    assign dp_stat.unit_last = unit_last;

    always_ff @(posedge aclk) begin
        if (cmd.load_hdr) begin
            codec_reg <= s_tdata[7:0];
            fi_reg    <= s_tdata[23:8];
            src_reg   <= s_tdata[31:24];
            fec_reg   <= s_tdata[39:32];
            usize_reg <= s_tdata[47:40];
            total_reg <= s_tdata[63:48];
            bytes_reg <= s_tdata[87:64];
        end
        if (cmd.start) begin
            idx_reg    <= '0;
            offset_reg <= '0;
        end else if (cmd.emit_unit) begin
            idx_reg    <= idx_reg + UW'(1);
            offset_reg <= offset_reg + 14'(usize_reg);
        end
        if (cmd.emit_err) begin
            o_status_reg <= err_code;
            o_frame_reg  <= '0;
            o_offset_reg <= '0;
            o_len_reg    <= '0;
            o_fec_reg    <= 1'b0;
            o_last_reg   <= 1'b1;
        end else if (cmd.emit_unit) begin
            o_status_reg <= skip ? STAT_SKIP : (newer ? STAT_DELIVERED : STAT_STALE);
            o_frame_reg  <= frame;
            o_offset_reg <= offset_reg;
            o_len_reg    <= usize_reg;
            o_fec_reg    <= !is_src;
            o_last_reg   <= unit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_frame_reg <= '0;
            startup_reg    <= 1'b1;
        end else begin
            if (cmd.start && fi_reg > HALF_RANGE) startup_reg <= 1'b0;
            if (cmd.emit_unit && !skip && newer) last_frame_reg <= frame;
        end
    end

    assign m_tdata = {2'b00, o_len_reg, o_offset_reg, o_frame_reg};
    assign m_tuser = {o_fec_reg, o_status_reg};
    assign m_tlast = o_last_reg;

endmodule

// File: hw/rtl/audio_fec_unit_sequencer.sv
// Audio fec unit sequencer: checks one audio packet header per input item and
// emits one result per unit (source units first, then fec units), or one error
// result for a rejected header. The last result of every item has tlast set.
// Channels: s_ carries the packed header, m_ carries the per-unit results,
// both accepted when tvalid and tready are high at a rising edge.
// Timing: an accepted header passes through the check state; a passing header
// then moves to the unit state, where one result is loaded per cycle from the
// unit counter while the output register is free, and a rejected header has
// its single error result loaded from the check state.
// One packet is in work at a time.
// A result sits in the output register until taken; the unit walk pauses
// while that register is full and not being read, and s_tready stays low
// until the final result of the packet is loaded.
// Reset (aresetn low, synchronous) empties the output register, returns the
// controller to idle, clears the stored last frame and sets startup.
// Depends on afus_pkg, afus_ctrl and afus_datapath.
module audio_fec_unit_sequencer import afus_pkg::*; #(
    parameter int MAX_UNITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // codec_id[7:0], first frame number[23:8], source_units[31:24],
    // fec_units[39:32], bytes per unit[47:40], units_total[63:48],
    // payload_bytes[87:64]
    input  logic [HDR_W-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_frame[15:0], unit_offset[29:16], unit_length[37:30], zero fill[39:38]
    output logic [ODAT_W-1:0] m_tdata,
    // status[2:0], is_fec[3]
    output logic [OUSR_W-1:0] m_tuser,
    output logic              m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    afus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    afus_datapath #(
        .MAX_UNITS (MAX_UNITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .dp_stat  (dp_stat),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/afus_checker.sv
// port-level checks for audio_fec_unit_sequencer, attached by bind
// depends on afus_pkg for the status codes
module afus_checker import afus_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [ODAT_W-1:0] m_tdata,
    input logic [OUSR_W-1:0] m_tuser,
    input logic              m_tlast
);

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // one packet at a time: input closes after an accept
    a_one_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // error results are single, final and carry zeroed unit fields
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == STAT_BAD_CODEC || m_tuser[2:0] == STAT_EMPTY
            || m_tuser[2:0] == STAT_COUNT || m_tuser[2:0] == STAT_SIZE
            || m_tuser[2:0] == STAT_TOO_MANY)
        |-> m_tlast && m_tdata == '0 && !m_tuser[3])
        else $error("malformed error result");

    a_skip_fec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == STAT_SKIP |-> m_tuser[3])
        else $error("startup skip on a source unit");

endmodule

bind audio_fec_unit_sequencer afus_checker u_afus_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/audio_fec_unit_sequencer_test.sv
// testbench for audio_fec_unit_sequencer: drives packet headers on s_, checks per-unit
// results on m_ against an in-bench prediction of frame numbering and stale marking
// depends on afus_pkg and the audio_fec_unit_sequencer rtl
`timescale 1ns / 100ps

module audio_fec_unit_sequencer_test;
    import afus_pkg::*;

    localparam int MAX_UNITS = 64;

    // msb first, so codec_id lands in the lowest bits of s_tdata
    typedef struct packed {
        logic [23:0] payload_bytes;
        logic [15:0] units_total;
        logic [7:0]  unit_bytes;
        logic [7:0]  fec_units;
        logic [7:0]  source_units;
        logic [15:0] first_frame;
        logic [7:0]  codec_id;
    } hdr_t;

    typedef struct {
        hdr_t hdr;
        bit   drain;  // hold this item until every result so far has come back
    } pending_t;

    typedef struct {
        status_t     status;
        logic [15:0] frame;
        logic [13:0] offset;
        logic [7:0]  length;
        logic        is_fec;
        logic        last;
    } unit_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [HDR_W-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ODAT_W-1:0] m_tdata;
    logic [OUSR_W-1:0] m_tuser;
    logic              m_tlast;

    pending_t     pending_hdrs[$];
    unit_result_t expected_units[$];
    logic [15:0]  pred_last_frame;
    bit           pred_startup;
    int           tx_gap = 0;
    int           rx_stall = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int           mismatches = 0;

    audio_fec_unit_sequencer #(.MAX_UNITS(MAX_UNITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic hdr_t make_hdr(int codec, int fi, int src, int fec, int usize,
                                      int total, int bytes);
        hdr_t h;
        h.codec_id      = 8'(codec);
        h.first_frame   = 16'(fi);
        h.source_units  = 8'(src);
        h.fec_units     = 8'(fec);
        h.unit_bytes    = 8'(usize);
        h.units_total   = 16'(total);
        h.payload_bytes = 24'(bytes);
        return h;
    endfunction

    // header checks, then one expected result per unit with serial-order frame tracking
    function automatic void split_packet(hdr_t h);
        status_t      verdict;
        int           n;
        int           k;
        unit_result_t r;
        verdict = STAT_DELIVERED;
        k = 0;
        if (h.codec_id != CODEC_OK)
            verdict = STAT_BAD_CODEC;
        else if (h.payload_bytes == 24'd0)
            verdict = STAT_EMPTY;
        else if (int'(h.source_units) + int'(h.fec_units) != int'(h.units_total))
            verdict = STAT_COUNT;
        else if (int'(h.payload_bytes) != int'(h.unit_bytes) * int'(h.units_total))
            verdict = STAT_SIZE;
        else if (int'(h.units_total) > MAX_UNITS)
            verdict = STAT_TOO_MANY;
        if (verdict != STAT_DELIVERED) begin
            expected_units.push_back('{verdict, 16'd0, 14'd0, 8'd0, 1'b0, 1'b1});
            return;
        end
        if (h.first_frame > HALF_RANGE)
            pred_startup = 1'b0;
        n = int'(h.source_units) + int'(h.fec_units);
        for (int i = 0; i < n; i++) begin
            r.offset = 14'(int'(h.unit_bytes) * i);
            r.length = h.unit_bytes;
            r.last   = (i == n - 1);
            if (i < int'(h.source_units)) begin
                r.frame  = h.first_frame + 16'(i);
                r.is_fec = 1'b0;
            end else begin
                k        = i - int'(h.source_units);
                r.frame  = h.first_frame - 16'(h.fec_units) + 16'(k);
                r.is_fec = 1'b1;
            end
            // startup duplicate check is done on plain integers, no wrap
            if (r.is_fec && pred_startup && int'(h.first_frame) + k < int'(h.fec_units) + 1) begin
                r.status = STAT_SKIP;
            end else if ((r.frame > pred_last_frame && r.frame - pred_last_frame < HALF_RANGE) ||
                         (r.frame < pred_last_frame && pred_last_frame - r.frame > HALF_RANGE)) begin
                r.status        = STAT_DELIVERED;
                pred_last_frame = r.frame;
            end else begin
                r.status = STAT_STALE;
            end
            expected_units.push_back(r);
        end
    endfunction

    // sender: one header per item, random gap after each accepted item
    always @(posedge aclk) begin
        bit nvalid;
        int ngap;
        if (!aresetn) begin
            s_tvalid        <= 1'b0;
            tx_gap          <= 0;
            pred_last_frame = 16'd0;
            pred_startup    = 1'b1;
        end else begin
            nvalid = s_tvalid;
            ngap   = tx_gap;
            if (s_tvalid && s_tready) begin
                split_packet(hdr_t'(s_tdata));
                nvalid = 1'b0;
                if ($urandom_range(0, 24) == 0)
                    tx_calm = !tx_calm;
                ngap = tx_calm ? 0 : $urandom_range(0, 18);
            end
            if (!nvalid) begin
                if (ngap > 0) begin
                    ngap--;
                end else if (pending_hdrs.size() != 0 &&
                             (!pending_hdrs[0].drain || expected_units.size() == 0)) begin
                    s_tdata <= pending_hdrs[0].hdr;
                    pending_hdrs.pop_front();
                    nvalid = 1'b1;
                end
            end
            s_tvalid <= nvalid;
            tx_gap   <= ngap;
        end
    end

    // receiver: compare each result with the oldest expectation, random stalls
    always @(posedge aclk) begin
        unit_result_t want;
        int           nstall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            nstall = rx_stall;
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: tuser=%h tdata=%h tlast=%b",
                                 m_tuser, m_tdata, m_tlast);
                end else begin
                    want = expected_units.pop_front();
                    if (m_tuser[2:0] !== want.status || m_tdata[15:0] !== want.frame ||
                        m_tdata[29:16] !== want.offset || m_tdata[37:30] !== want.length ||
                        m_tuser[3] !== want.is_fec || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: want status=%0d frame=%h off=%0d len=%0d fec=%b last=%b",
                                     want.status, want.frame, want.offset, want.length,
                                     want.is_fec, want.last);
                            $display("          got  status=%0d frame=%h off=%0d len=%0d fec=%b last=%b",
                                     m_tuser[2:0], m_tdata[15:0], m_tdata[29:16],
                                     m_tdata[37:30], m_tuser[3], m_tlast);
                        end
                    end
                end
                if ($urandom_range(0, 24) == 0)
                    rx_calm = !rx_calm;
                nstall = rx_calm ? 0 : $urandom_range(0, 18);
            end else if (nstall > 0) begin
                nstall--;
            end
            rx_stall <= nstall;
            m_tready <= (nstall == 0);
        end
    end

    // stimulus and end of run
    initial begin
        hdr_t        h;
        int          total;
        int          src;
        int          fec;
        int          usize;
        logic [15:0] next_fi;
        int          guard;

        // startup phase: duplicate fec units at the start of the stream
        pending_hdrs.push_back('{make_hdr(5, 0, 2, 2, 10, 4, 40), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 1, 1, 3, 4, 4, 16), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 3, 0, 1, 255, 1, 255), 1'b0});
        // rejected header with a high frame index must not end startup
        pending_hdrs.push_back('{make_hdr(4, 40000, 1, 1, 1, 2, 2), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 2, 0, 4, 1, 4, 4), 1'b0});
        // each rejection, field extremes
        pending_hdrs.push_back('{make_hdr(0, 0, 0, 0, 0, 0, 0), 1'b0});
        pending_hdrs.push_back('{make_hdr(255, 65535, 255, 255, 255, 65535, 24'hFFFFFF), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 1, 1, 8, 2, 0), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 1, 1, 8, 3, 24), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 1, 1, 8, 2, 17), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 0, 0, 8, 0, 5), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 0, 0, 0, 0, 0), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 40, 25, 1, 65, 65), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 10, 255, 255, 255, 510, 130050), 1'b0});
        // exactly half range keeps startup, one above ends it
        pending_hdrs.push_back('{make_hdr(5, 32768, 1, 1, 2, 2, 4), 1'b1});
        pending_hdrs.push_back('{make_hdr(5, 32769, 32, 32, 255, 64, 16320), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 100, 0, 3, 7, 3, 21), 1'b0});
        // frame wrap, then a frame exactly half range away, then an equal frame
        pending_hdrs.push_back('{make_hdr(5, 65535, 3, 0, 9, 3, 27), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 32769, 1, 0, 1, 1, 1), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 1, 1, 0, 1, 1, 1), 1'b0});
        pending_hdrs.push_back('{make_hdr(5, 0, 0, 1, 255, 1, 255), 1'b0});

        next_fi = 16'd40000;
        for (int n = 0; n < 300; n++) begin
            total   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_UNITS)
                                                 : $urandom_range(1, 8);
            src     = $urandom_range(0, total);
            fec     = total - src;
            usize   = $urandom_range(1, 255);
            h       = make_hdr(5, 0, src, fec, usize, total, usize * total);
            case ($urandom_range(0, 9))
                0: h.first_frame = 16'($urandom_range(0, 65535));
                1: h.first_frame = 16'(next_fi - $urandom_range(1, 40));
                default: h.first_frame = 16'(next_fi + $urandom_range(0, 2));
            endcase
            next_fi = 16'(h.first_frame + total);
            // about one in five is malformed
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0: h = make_hdr($urandom_range(0, 255), $urandom_range(0, 65535),
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 65535),
                                    $urandom_range(0, 24'hFFFFFF));
                    1: h.codec_id = 8'($urandom_range(0, 255));
                    2: h.payload_bytes = 24'd0;
                    3: h.units_total = 16'(h.units_total + $urandom_range(1, 300));
                    4: h.payload_bytes = h.payload_bytes ^ (24'd1 << $urandom_range(0, 23));
                    default: begin
                        total = $urandom_range(MAX_UNITS + 1, 510);
                        src   = (total > 255) ? $urandom_range(total - 255, 255)
                                              : $urandom_range(0, total);
                        h = make_hdr(5, $urandom_range(0, 65535), src, total - src, usize,
                                     total, usize * total);
                    end
                endcase
            end
            pending_hdrs.push_back('{h, $urandom_range(0, 49) == 0});
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_hdrs.size() != 0 || s_tvalid)
            @(posedge aclk);
        guard = 0;
        while (expected_units.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (expected_units.size() != 0)
            mismatches++;
        if (mismatches == 0) begin
            $display("audio_fec_unit_sequencer_test: clean");
        end else begin
            $display("audio_fec_unit_sequencer_test: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("audio_fec_unit_sequencer_test: errors");
        $finish;
    end

endmodule

// File: audio_fec_unit_sequencer.f
hw/rtl/afus_pkg.sv
hw/rtl/afus_ctrl.sv
hw/rtl/afus_datapath.sv
hw/rtl/audio_fec_unit_sequencer.sv
hw/rtl/afus_checker.sv
sim/audio_fec_unit_sequencer_test.sv
